// File: src/btc_pkg.sv
// Shared types, constants and ranking helpers for the barcode top-two caller.
package btc_pkg;

    localparam int          NUM_BARCODES_DEF = 128;
    localparam int          SCORE_W          = 15;
    localparam int          ID_W             = 8;
    localparam int          CFG_IDX_W        = 2;
    localparam logic [7:0]  NONE_ID          = 8'd128;
    localparam logic [14:0] SCORE_MAX        = 15'd25600;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTH_ENDS = 2'd2;

    localparam logic [14:0] THRESHOLD_RST = 15'd19200;
    localparam logic [14:0] MARGIN_RST    = 15'd1280;

    typedef struct packed {
        logic        entry_valid;
        logic        side;
        logic [6:0]  barcode_id;
        logic [14:0] score;
        logic        last_entry;
        logic        external_present;
        logic [7:0]  external_call_id;
    } t_in;

    typedef struct packed {
        logic [7:0]  call_id;
        logic [7:0]  best_start_id;
        logic [14:0] best_start_score;
        logic [7:0]  second_start_id;
        logic [14:0] second_start_score;
        logic [7:0]  best_end_id;
        logic [14:0] best_end_score;
        logic [7:0]  second_end_id;
        logic [14:0] second_end_score;
    } t_out;

    // true if (ia, sa) ranks above (ib, sb): higher score, then lower id
    function automatic logic ranks_above(input logic [7:0] ia, input logic [14:0] sa,
                                         input logic [7:0] ib, input logic [14:0] sb);
        logic r;
        if (sa != sb) begin
            r = (sa > sb);
        end else begin
            r = (ia < ib);
        end
        return r;
    endfunction

    function automatic logic passes(input logic [14:0] best, input logic [14:0] second,
                                    input logic [14:0] thr, input logic [14:0] margin);
        logic [15:0] need;
        need = {1'b0, second} + {1'b0, margin};
        return (best >= thr) && ({1'b0, best} >= need);
    endfunction

endpackage

// File: src/barcode_top_two_call.sv
// An accepted last_entry passes the input and snapshot registers to the result register.
// Throughput: one input per cycle unless o_in_stall; results leave via a registered stage.
// Stages: input register, slot update and snapshot, call decision into the result register.
// Reset (synchronous, active low): empties the pipeline, sets all four slots to none
// with score 0, and loads threshold 19200, margin 1280, single-ended mode.
// Top level of the barcode top-two caller.
module barcode_top_two_call #(
    parameter int NUM_BARCODES = btc_pkg::NUM_BARCODES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  btc_pkg::t_in                   i_in_data,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output btc_pkg::t_out                  o_out_data,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_we,
    input  logic [btc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [btc_pkg::SCORE_W-1:0]    i_cfg_data
);
    import btc_pkg::*;

    localparam logic [8:0] NB = 9'(NUM_BARCODES);

    logic [14:0] r_threshold;
    logic [14:0] r_margin;
    logic        r_both_ends;

    logic        r_v1;
    t_in         r_in;
    logic        r_v2;
    logic [7:0]  r_ids [4];
    logic [14:0] r_scores [4];
    logic [7:0]  r_snap_ids [4];
    logic [14:0] r_snap_scores [4];
    logic        r_ext_present;
    logic [7:0]  r_ext_id;
    logic        r_out_v;
    t_out        r_out;

    logic        ready2, ready3, mv12, mv23, load;
    logic [14:0] s_sat;
    logic        take;
    logic [7:0]  n_ids [4];
    logic [14:0] n_scores [4];
    logic [7:0]  new_id;

    assign ready3     = !r_out_v || !i_out_stall;
    assign mv23       = r_v2 && ready3;
    assign ready2     = !r_v2 || mv23;
    assign mv12       = r_v1 && ready2;
    assign o_in_stall = r_v1 && !ready2;
    assign load       = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_margin    <= MARGIN_RST;
            r_both_ends <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_MARGIN:    r_margin    <= i_cfg_data;
                CFG_BOTH_ENDS: r_both_ends <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (load) begin
            r_v1 <= 1'b1;
        end else if (mv12) begin
            r_v1 <= 1'b0;
        end
        if (load) begin
            r_in <= i_in_data;
        end
    end

    // slot update
    always_comb begin
        s_sat  = (r_in.score > SCORE_MAX) ? SCORE_MAX : r_in.score;
        take   = r_in.entry_valid && ({2'b00, r_in.barcode_id} < NB);
        new_id = {1'b0, r_in.barcode_id};
        for (int k = 0; k < 4; k++) begin
            n_ids[k]    = r_ids[k];
            n_scores[k] = r_scores[k];
        end
        for (int s = 0; s < 2; s++) begin
            if (take && (r_in.side == s[0])) begin
                if (ranks_above(new_id, s_sat, r_ids[2*s], r_scores[2*s])) begin
                    n_ids[2*s+1]    = r_ids[2*s];
                    n_scores[2*s+1] = r_scores[2*s];
                    n_ids[2*s]      = new_id;
                    n_scores[2*s]   = s_sat;
                end else if (ranks_above(new_id, s_sat, r_ids[2*s+1],
                                         r_scores[2*s+1])) begin
                    n_ids[2*s+1]    = new_id;
                    n_scores[2*s+1] = s_sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_ids[k]    <= NONE_ID;
                r_scores[k] <= '0;
            end
        end else if (mv12) begin
            r_v2 <= r_in.last_entry;
            for (int k = 0; k < 4; k++) begin
                r_ids[k]    <= r_in.last_entry ? NONE_ID : n_ids[k];
                r_scores[k] <= r_in.last_entry ? 15'd0 : n_scores[k];
            end
        end else if (mv23) begin
            r_v2 <= 1'b0;
        end
        if (mv12 && r_in.last_entry) begin
            for (int k = 0; k < 4; k++) begin
                r_snap_ids[k]    <= n_ids[k];
                r_snap_scores[k] <= n_scores[k];
            end
            r_ext_present <= r_in.external_present;
            r_ext_id      <= r_in.external_call_id;
        end
    end

    // call decision
    logic [7:0]  bi, pa_id, pb_id, si;
    logic [14:0] bs, pa_sc, pb_sc, ss;
    logic        el [4];
    logic        pa_ok, pb_ok;
    logic [7:0]  call;

    always_comb begin
        if (ranks_above(r_snap_ids[2], r_snap_scores[2], r_snap_ids[0], r_snap_scores[0]))
        begin
            bi = r_snap_ids[2];
            bs = r_snap_scores[2];
        end else begin
            bi = r_snap_ids[0];
            bs = r_snap_scores[0];
        end
        for (int k = 0; k < 4; k++) begin
            el[k] = (r_snap_ids[k] != NONE_ID) && (r_snap_ids[k] != bi);
        end
        // best eligible of slots 0/1 and of slots 2/3
        if (el[1] && (!el[0] || ranks_above(r_snap_ids[1], r_snap_scores[1],
                                             r_snap_ids[0], r_snap_scores[0]))) begin
            pa_id = r_snap_ids[1];
            pa_sc = r_snap_scores[1];
        end else begin
            pa_id = r_snap_ids[0];
            pa_sc = r_snap_scores[0];
        end
        pa_ok = el[0] || el[1];
        if (el[3] && (!el[2] || ranks_above(r_snap_ids[3], r_snap_scores[3],
                                             r_snap_ids[2], r_snap_scores[2]))) begin
            pb_id = r_snap_ids[3];
            pb_sc = r_snap_scores[3];
        end else begin
            pb_id = r_snap_ids[2];
            pb_sc = r_snap_scores[2];
        end
        pb_ok = el[2] || el[3];
        if (pb_ok && (!pa_ok || ranks_above(pb_id, pb_sc, pa_id, pa_sc))) begin
            si = pb_id;
            ss = pb_sc;
        end else if (pa_ok) begin
            si = pa_id;
            ss = pa_sc;
        end else begin
            si = NONE_ID;
            ss = '0;
        end

        call = NONE_ID;
        if (r_both_ends) begin
            if (passes(r_snap_scores[0], r_snap_scores[1], r_threshold, r_margin) &&
                passes(r_snap_scores[2], r_snap_scores[3], r_threshold, r_margin) &&
                (r_snap_ids[0] == r_snap_ids[2])) begin
                call = r_snap_ids[0];
            end
        end else if (passes(bs, ss, r_threshold, r_margin)) begin
            call = bi;
        end
        if (r_ext_present && (call != r_ext_id)) begin
            call = NONE_ID;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (mv23) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
        if (mv23) begin
            r_out.call_id            <= call;
            r_out.best_start_id      <= r_snap_ids[0];
            r_out.best_start_score   <= r_snap_scores[0];
            r_out.second_start_id    <= r_snap_ids[1];
            r_out.second_start_score <= r_snap_scores[1];
            r_out.best_end_id        <= r_snap_ids[2];
            r_out.best_end_score     <= r_snap_scores[2];
            r_out.second_end_id      <= r_snap_ids[3];
            r_out.second_end_score   <= r_snap_scores[3];
        end
    end

endmodule
